[sv/mrsp_pkg.sv]
// types and constants for the midi running status parser
// shared by mrsp_decode and midi_running_status_parser_unit, no dependencies
package mrsp_pkg;

  localparam logic [7:0] REALTIME_FIRST  = 8'hF8;
  localparam logic [7:0] SYSCOMMON_FIRST = 8'hF0;
  localparam logic [7:0] NO_STATUS       = 8'h00;
  localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
  localparam logic [3:0] TYPE_AFTERTOUCH = 4'hD;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [7:0] running_status;
    logic [6:0] first_data;
    logic       have_first;
  } parse_state_t;

  typedef struct packed {
    parse_state_t state;
    logic         emit;
    logic [7:0]   msg_status;
    logic [6:0]   msg_data1;
    logic [6:0]   msg_data2;
  } parse_step_t;

endpackage

[sv/mrsp_decode.sv]
// per-byte decision of the running status parser: next state and result
// depends on mrsp_pkg
module mrsp_decode (
  input  mrsp_pkg::req_type_t    req_type,
  input  logic [7:0]             rx_byte,
  input  mrsp_pkg::parse_state_t state,
  output mrsp_pkg::parse_step_t  step
);
  import mrsp_pkg::*;

  logic [3:0] kind;

  assign kind = state.running_status[7:4];

  always_comb begin
    step            = '0;
    step.state      = state;
    step.msg_status = state.running_status;
    step.msg_data1  = state.first_data;
    step.msg_data2  = rx_byte[6:0];
    if (req_type == REQ_CLEAR) begin
      step.state.running_status = NO_STATUS;
      step.state.have_first     = 1'b0;
    end else if (rx_byte >= REALTIME_FIRST) begin
      step.state = state;
    end else if (rx_byte[7]) begin
      step.state.running_status = (rx_byte >= SYSCOMMON_FIRST) ? NO_STATUS : rx_byte;
      step.state.have_first     = 1'b0;
    end else if (state.running_status == NO_STATUS) begin
      step.state = state;
    end else if (!state.have_first) begin
      step.state.first_data = rx_byte[6:0];
      step.state.have_first = !((kind == TYPE_PROGRAM) || (kind == TYPE_AFTERTOUCH));
    end else begin
      step.emit             = 1'b1;
      step.state.have_first = 1'b0;
    end
  end

endmodule

[sv/midi_running_status_parser_unit.sv]
// midi running status parser, top level with input and result registers
// depends on mrsp_pkg and mrsp_decode
// an accepted input word is held in the input register and decoded, and its result goes to the result register
// throughput: one input word per cycle, set by the single decode stage
// a full result register stalls only words that produce a result
// rst (synchronous, active high) clears running status, pending data and valids
module midi_running_status_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mrsp_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // rx_byte[7:0]
  input  logic                                s_axis_tuser,   // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mrsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata    // msg_status[7:0], msg_data1[14:8],
                                                              // msg_data2[21:15], zero[23:22]
);
  import mrsp_pkg::*;

  logic          in_valid;
  req_type_t     in_req;
  logic [7:0]    in_byte;
  parse_state_t  state;
  parse_step_t   step;
  logic          out_free;
  logic          advance;
  logic [OUT_DATA_W-1:0] out_data;

  mrsp_decode u_decode (
    .req_type (in_req),
    .rx_byte  (in_byte),
    .state    (state),
    .step     (step)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!step.emit || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= req_type_t'(s_axis_tuser);
      in_byte <= s_axis_tdata;
    end
    if (advance && step.emit) begin
      out_data <= {2'b00, step.msg_data2, step.msg_data1, step.msg_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state         <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        state <= step.state;
      end
      if (advance && step.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // results always carry a channel status byte
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7] && (m_axis_tdata[7:4] != 4'hF)))
    else $error("result without channel status");

  // pending first data only under a two-data-byte status
  a_pending: assert property (@(posedge clk) disable iff (rst)
    state.have_first |-> (state.running_status[7] &&
      (state.running_status[7:4] != TYPE_PROGRAM) &&
      (state.running_status[7:4] != TYPE_AFTERTOUCH) &&
      (state.running_status[7:4] != 4'hF)))
    else $error("pending data byte with bad running status");

  // a clear request leaves no status behind
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_req == REQ_CLEAR)) |=> ((state.running_status == NO_STATUS) &&
      !state.have_first))
    else $error("clear request left parser state");

  // a result is only produced from a pending first data byte
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (advance && step.emit) |-> (state.have_first && !in_byte[7]))
    else $error("result without pending data byte");

  // a stalled result holds the input stage when the word would produce another
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && step.emit && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stage blocked");

endmodule
